// ----- rtl/mrcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus register and coil server package
// Request and response types, request codes, function codes and reset
// contents shared by the server core and the header calculator.
// ----------------------------------------------------------------------------
package mrcs_pkg;

  // Request types
  localparam logic [2:0] REQ_HEADER   = 3'd0;
  localparam logic [2:0] REQ_RD_REG   = 3'd1;
  localparam logic [2:0] REQ_WR_REG   = 3'd2;
  localparam logic [2:0] REQ_RD_COILS = 3'd3;
  localparam logic [2:0] REQ_WR_COIL  = 3'd4;

  // Modbus function codes that change the reply header
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

  // Reply length overheads
  localparam logic [15:0] HDR_OVERHEAD = 16'd3;
  localparam logic [15:0] WR_MULTI_LEN = 16'd6;

  // Reset contents
  localparam logic [15:0] HREG_RESET0     = 16'hABCD;
  localparam logic [15:0] HREG_RESET1     = 16'hDEAD;
  localparam logic [7:0]  COIL_ROW0_RESET = 8'h12;
  localparam logic [7:0]  LIMIT_RESET     = 8'd100;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  function_code;
    logic [15:0] address;
    logic [10:0] quantity;
    logic [15:0] request_length;
    logic [15:0] write_value;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [11:0] byte_count;
    logic [15:0] reply_length;
    logic        in_range;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WAIT1,
    ST_WAIT2
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/mrcs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mrcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  wire  logic                    clk_i,
  input  wire  logic                    we_i,
  input  wire  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire  logic [Width-1:0]        wdata_i,
  input  wire  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/mrcs_hdr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus reply header calculator
// Works out the reply data byte count and the MBAP reply length.
// ----------------------------------------------------------------------------
module mrcs_hdr (
  input  wire  logic [7:0]  function_code_i,
  input  wire  logic [10:0] quantity_i,
  input  wire  logic [15:0] request_length_i,
  output logic [11:0]       byte_count_o,
  output logic [15:0]       reply_length_o
);

  logic [11:0] bits_bytes;
  logic [11:0] regs_bytes;

  assign bits_bytes = (12'(quantity_i) + 12'd7) >> 3;
  assign regs_bytes = {quantity_i, 1'b0};

  always_comb begin
    case (function_code_i) inside
      mrcs_pkg::FC_READ_COILS, mrcs_pkg::FC_READ_DISCRETE: begin
        byte_count_o   = bits_bytes;
        reply_length_o = 16'(bits_bytes) + mrcs_pkg::HDR_OVERHEAD;
      end
      mrcs_pkg::FC_READ_HOLDING, mrcs_pkg::FC_READ_INPUT: begin
        byte_count_o   = regs_bytes;
        reply_length_o = 16'(regs_bytes) + mrcs_pkg::HDR_OVERHEAD;
      end
      mrcs_pkg::FC_WRITE_MULTI: begin
        byte_count_o   = '0;
        reply_length_o = mrcs_pkg::WR_MULTI_LEN;
      end
      default: begin
        byte_count_o   = '0;
        reply_length_o = request_length_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/modbus_register_coil_server_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus register and coil server core
// Holding-register table and coil table with address limit checking.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Exactly one result
// follows, shown on rsp_o for one cycle while done_o is high; the receiver
// must take it then, as it cannot hold results off.
// Header, register write and unknown-type requests finish in the execute
// state that follows acceptance; register reads and coil writes go on to
// the first wait state, and eight-coil reads on to the second.
// busy falls in the cycle the result is shown, so a new request may be
// taken alongside it. The wait states come from the registered reads
// of the register and coil memories; an eight-coil read needs two coil
// rows read one after the other, and a coil write is read-modify-write.
// The limit register is written over cfg_* and is always
// ready; it should only change while the block is idle.
// After reset the block clears both tables to their reset contents, one
// entry a cycle, holding busy high until the last entry is written.
// ----------------------------------------------------------------------------
module modbus_register_coil_server_core #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  wire  logic          clk_i,
  input  wire  logic          rst_ni,
  input  wire  logic          start,
  output logic                busy,
  input  wire  mrcs_pkg::req_t req_i,
  output logic                done_o,
  output mrcs_pkg::rsp_t      rsp_o,
  input  wire  logic          cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  logic [7:0]    cfg_data_i
);

  localparam int unsigned AW       = $clog2(TABLE_DEPTH);
  localparam int unsigned CoilRows = (TABLE_DEPTH + 7) / 8;
  localparam int unsigned RowW     = (CoilRows > 1) ? $clog2(CoilRows) : 1;

  mrcs_pkg::state_e state_q, state_d;
  mrcs_pkg::req_t   req_q, req_d;
  mrcs_pkg::rsp_t   rsp_q, rsp_d;
  logic             done_q, done_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [7:0]       coil_lo_q, coil_lo_d;
  logic [7:0]       limit_q;

  logic             reg_we;
  logic [AW-1:0]    reg_waddr;
  logic [15:0]      reg_wdata;
  logic [15:0]      reg_rdata;
  logic             coil_we;
  logic [RowW-1:0]  coil_waddr;
  logic [RowW-1:0]  coil_raddr;
  logic [7:0]       coil_wdata;
  logic [7:0]       coil_rdata;

  logic             hit;
  logic [7:0]       coil_mask;
  logic [7:0]       coil_window;
  logic [7:0]       coil_row_mod;
  logic [12:0]      row_cur;
  logic [12:0]      row_next;
  logic [11:0]      hdr_byte_count;
  logic [15:0]      hdr_reply_length;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mrcs_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  mrcs_ram #(.Width(16), .Depth(TABLE_DEPTH)) u_hreg_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .raddr_i (req_q.address[AW-1:0]),
    .rdata_o (reg_rdata)
  );

  mrcs_ram #(.Width(8), .Depth(CoilRows)) u_coil_ram (
    .clk_i   (clk_i),
    .we_i    (coil_we),
    .waddr_i (coil_waddr),
    .wdata_i (coil_wdata),
    .raddr_i (coil_raddr),
    .rdata_o (coil_rdata)
  );

  mrcs_hdr u_hdr (
    .function_code_i  (req_q.function_code),
    .quantity_i       (req_q.quantity),
    .request_length_i (req_q.request_length),
    .byte_count_o     (hdr_byte_count),
    .reply_length_o   (hdr_reply_length)
  );

  assign hit = (17'(req_q.address) < 17'(limit_q)) &&
               (17'(req_q.address) < 17'(TABLE_DEPTH));

  assign row_cur  = req_q.address[15:3];
  assign row_next = row_cur + 13'd1;

  // Each of the eight coils is checked against the limit on its own.
  always_comb begin
    logic [16:0] ca;
    ca = '0;
    for (int i = 0; i < 8; i++) begin
      ca = 17'(req_q.address) + 17'(i);
      coil_mask[i] = (ca < 17'(limit_q)) && (ca < 17'(TABLE_DEPTH));
    end
  end

  // The eight coils start anywhere in the lower row and run into the next.
  always_comb begin
    logic [15:0] pair;
    pair        = {coil_rdata, coil_lo_q};
    coil_window = 8'(pair >> req_q.address[2:0]) & coil_mask;
  end

  always_comb begin
    coil_row_mod = coil_rdata;
    coil_row_mod[req_q.address[2:0]] = (req_q.write_value != 16'd0);
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    clr_d      = clr_q;
    coil_lo_d  = coil_lo_q;
    reg_we     = 1'b0;
    reg_waddr  = req_q.address[AW-1:0];
    reg_wdata  = req_q.write_value;
    coil_we    = 1'b0;
    coil_waddr = row_cur[RowW-1:0];
    coil_wdata = coil_row_mod;
    coil_raddr = row_cur[RowW-1:0];
    busy       = 1'b1;

    unique case (state_q)
      mrcs_pkg::ST_CLEAR: begin
        reg_we    = 1'b1;
        reg_waddr = clr_q;
        if (clr_q == AW'(0)) begin
          reg_wdata = mrcs_pkg::HREG_RESET0;
        end else if (clr_q == AW'(1)) begin
          reg_wdata = mrcs_pkg::HREG_RESET1;
        end else begin
          reg_wdata = '0;
        end
        coil_we    = ({1'b0, clr_q} < (AW+1)'(CoilRows));
        coil_waddr = clr_q[RowW-1:0];
        coil_wdata = (clr_q == AW'(0)) ? mrcs_pkg::COIL_ROW0_RESET : 8'd0;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = mrcs_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      mrcs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          req_d   = req_i;
          state_d = mrcs_pkg::ST_EXEC;
        end
      end
      mrcs_pkg::ST_EXEC: begin
        rsp_d = '0;
        case (req_q.req_type)
          mrcs_pkg::REQ_HEADER: begin
            rsp_d.byte_count   = hdr_byte_count;
            rsp_d.reply_length = hdr_reply_length;
            rsp_d.in_range     = hit;
            done_d             = 1'b1;
            state_d            = mrcs_pkg::ST_IDLE;
          end
          mrcs_pkg::REQ_WR_REG: begin
            reg_we         = hit;
            rsp_d.in_range = hit;
            done_d         = 1'b1;
            state_d        = mrcs_pkg::ST_IDLE;
          end
          mrcs_pkg::REQ_RD_REG, mrcs_pkg::REQ_RD_COILS, mrcs_pkg::REQ_WR_COIL: begin
            state_d = mrcs_pkg::ST_WAIT1;
          end
          default: begin
            done_d  = 1'b1;
            state_d = mrcs_pkg::ST_IDLE;
          end
        endcase
      end
      mrcs_pkg::ST_WAIT1: begin
        rsp_d          = '0;
        rsp_d.in_range = hit;
        coil_raddr     = row_next[RowW-1:0];
        if (req_q.req_type == mrcs_pkg::REQ_RD_COILS) begin
          coil_lo_d = coil_rdata;
          state_d   = mrcs_pkg::ST_WAIT2;
        end else begin
          if (req_q.req_type == mrcs_pkg::REQ_RD_REG) begin
            rsp_d.read_data = hit ? reg_rdata : 16'd0;
          end else begin
            coil_we = hit;
          end
          done_d  = 1'b1;
          state_d = mrcs_pkg::ST_IDLE;
        end
      end
      mrcs_pkg::ST_WAIT2: begin
        rsp_d           = '0;
        rsp_d.in_range  = hit;
        rsp_d.read_data = {8'd0, coil_window};
        done_d          = 1'b1;
        state_d         = mrcs_pkg::ST_IDLE;
      end
      default: begin
        state_d = mrcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrcs_pkg::ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rsp_q     <= rsp_d;
    coil_lo_q <= coil_lo_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result only ever follows work on an accepted request.
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) != mrcs_pkg::ST_IDLE &&
                $past(state_q) != mrcs_pkg::ST_CLEAR))
    else $error("result strobe without a request in progress");

  // A request that is taken is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == mrcs_pkg::ST_EXEC))
    else $error("accepted request not executed");

  // Table writes outside the clearing pass must be in range.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((reg_we || coil_we) && state_q != mrcs_pkg::ST_CLEAR) |-> hit)
    else $error("table write outside the address limit");

  // Coil writes only happen while clearing or in the read-modify-write step.
  a_coil_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coil_we |-> (state_q == mrcs_pkg::ST_CLEAR ||
                 (state_q == mrcs_pkg::ST_WAIT1 &&
                  req_q.req_type == mrcs_pkg::REQ_WR_COIL)))
    else $error("coil row written outside read-modify-write");

  // No request is taken while the tables are being cleared.
  a_busy_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrcs_pkg::ST_CLEAR) |-> busy)
    else $error("not busy during clearing pass");

endmodule
`default_nettype wire
